// ----- rtl/cfcr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfcr_pkg
// Shared types and constants for the cube face coordinate resolver.
// ----------------------------------------------------------------------------
package cfcr_pkg;

	// face geometry
	localparam int SIDE   = 512;
	localparam int SIDE_W = $clog2(SIDE);
	localparam int POS_W  = 11;
	localparam int FACE_W = 3;
	localparam int HEAD_W = 8;

	localparam logic signed [POS_W-1:0] SIDE_POS  = POS_W'(SIDE);
	localparam logic [SIDE_W-1:0]       SIDE_LAST = SIDE_W'(SIDE - 1);

	// face numbers
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
	localparam logic [FACE_W-1:0] FACE_RING1  = 3'd1;
	localparam logic [FACE_W-1:0] FACE_RING2  = 3'd2;
	localparam logic [FACE_W-1:0] FACE_RING3  = 3'd3;
	localparam logic [FACE_W-1:0] FACE_RING4  = 3'd4;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

	// quarter-turn codes
	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_90   = 2'd1,
		TURN_180  = 2'd2,
		TURN_270  = 2'd3
	} turn_t;

	// one input word
	typedef struct packed {
		logic [FACE_W-1:0]        face;
		logic signed [POS_W-1:0]  x_pos;
		logic signed [POS_W-1:0]  y_pos;
		logic [HEAD_W-1:0]        heading;
	} coord_in_t;

	// one result word
	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [SIDE_W-1:0] x;
		logic [SIDE_W-1:0] y;
		logic [HEAD_W-1:0] heading;
	} coord_out_t;

endpackage

// ----- rtl/cfcr_resolve.sv -----
// ----------------------------------------------------------------------------
// cfcr_resolve
// Combinational edge resolution: wrap, neighbor move with rotation, or clamp.
// ----------------------------------------------------------------------------
module cfcr_resolve
	import cfcr_pkg::*;
(
	input  coord_in_t  in_word,
	output coord_out_t out_word
);

	logic              neg_x, pos_x, neg_y, pos_y, off_x, off_y;
	logic [SIDE_W-1:0] wx, wy, cx, cy;
	logic [FACE_W-1:0] nf;
	logic [SIDE_W-1:0] rx, ry;
	turn_t             turn;

	// edge detection and wrapped / clamped coordinates
	always_comb begin
		neg_x = in_word.x_pos < 0;
		pos_x = in_word.x_pos >= SIDE_POS;
		neg_y = in_word.y_pos < 0;
		pos_y = in_word.y_pos >= SIDE_POS;
		off_x = neg_x | pos_x;
		off_y = neg_y | pos_y;
		wx    = in_word.x_pos[SIDE_W-1:0];
		wy    = in_word.y_pos[SIDE_W-1:0];
		cx    = neg_x ? '0 : (pos_x ? SIDE_LAST : wx);
		cy    = neg_y ? '0 : (pos_y ? SIDE_LAST : wy);
	end

	// face move and turn selection
	always_comb begin
		nf   = in_word.face;
		turn = TURN_NONE;
		rx   = cx;
		ry   = cy;
		if (!off_x && !off_y) begin
			rx = wx;
			ry = wy;
		end else if ((off_x && off_y) || in_word.face > FACE_BOTTOM) begin
			rx = cx;
			ry = cy;
		end else if (!off_y) begin
			rx = wx;
			ry = wy;
			if (in_word.face >= FACE_RING1 && in_word.face <= FACE_RING4) begin
				if (neg_x)
					nf = (in_word.face == FACE_RING1) ? FACE_RING4 : in_word.face - 3'd1;
				else
					nf = (in_word.face == FACE_RING4) ? FACE_RING1 : in_word.face + 3'd1;
			end else if (neg_x) begin
				nf   = FACE_RING1;
				turn = TURN_270;
			end else begin
				nf   = FACE_RING3;
				turn = TURN_90;
			end
		end else begin
			rx = wx;
			ry = wy;
			case (in_word.face)
				FACE_TOP: begin
					if (neg_y) begin
						nf   = FACE_RING4;
						turn = TURN_180;
					end else begin
						nf = FACE_RING2;
					end
				end
				FACE_RING2: begin
					nf = neg_y ? FACE_TOP : FACE_BOTTOM;
				end
				FACE_BOTTOM: begin
					if (neg_y) begin
						nf = FACE_RING2;
					end else begin
						nf   = FACE_RING4;
						turn = TURN_180;
					end
				end
				FACE_RING1: begin
					nf   = neg_y ? FACE_TOP : FACE_BOTTOM;
					turn = neg_y ? TURN_90 : TURN_270;
				end
				FACE_RING3: begin
					nf   = neg_y ? FACE_TOP : FACE_BOTTOM;
					turn = neg_y ? TURN_270 : TURN_90;
				end
				default: begin
					nf   = neg_y ? FACE_TOP : FACE_BOTTOM;
					turn = TURN_180;
				end
			endcase
		end
	end

	// rotation of the wrapped position and heading
	always_comb begin
		out_word.face    = nf;
		out_word.x       = rx;
		out_word.y       = ry;
		out_word.heading = in_word.heading + {turn, 6'd0};
		case (turn)
			TURN_90: begin
				out_word.x = wy;
				out_word.y = SIDE_LAST - wx;
			end
			TURN_180: begin
				out_word.x = SIDE_LAST - wx;
				out_word.y = SIDE_LAST - wy;
			end
			TURN_270: begin
				out_word.x = SIDE_LAST - wy;
				out_word.y = wx;
			end
			default: begin
				out_word.x = rx;
				out_word.y = ry;
			end
		endcase
	end

endmodule

// ----- rtl/cube_face_coordinate_resolve_top.sv -----
// ----------------------------------------------------------------------------
// cube_face_coordinate_resolve_top
// Resolves a face position that may lie past one face edge on a six-face cube.
// ----------------------------------------------------------------------------
// One word in, one word out. Each word passes an input register and a result
// register with the edge resolution logic between them, so a result is
// presented on the output once the result register has loaded it. One word is
// taken every cycle as long as the output side does not stall. A stall on the
// output holds the result register; the input register still takes one more
// word before the input side is stalled.
module cube_face_coordinate_resolve_top
	import cfcr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [FACE_W-1:0]       face,
	input  logic signed [POS_W-1:0] x_pos,
	input  logic signed [POS_W-1:0] y_pos,
	input  logic [HEAD_W-1:0]       heading,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [FACE_W-1:0]       out_face,
	output logic [SIDE_W-1:0]       out_x,
	output logic [SIDE_W-1:0]       out_y,
	output logic [HEAD_W-1:0]       out_heading
);

	logic       valid_s1, valid_s2;
	coord_in_t  word_s1;
	coord_out_t word_s2;
	coord_out_t res_word;
	logic       adv_s2, adv_s1;

	// pipeline advance
	assign adv_s2   = !(valid_s2 && out_stall);
	assign adv_s1   = adv_s2 || !valid_s1;
	assign in_stall = !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv_s1)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1.face    <= face;
			word_s1.x_pos   <= x_pos;
			word_s1.y_pos   <= y_pos;
			word_s1.heading <= heading;
		end
	end

	// edge resolution
	cfcr_resolve u_resolve (
		.in_word  (word_s1),
		.out_word (res_word)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1)
			word_s2 <= res_word;
	end

	assign out_valid   = valid_s2;
	assign out_face    = word_s2.face;
	assign out_x       = word_s2.x;
	assign out_y       = word_s2.y;
	assign out_heading = word_s2.heading;

`ifndef ASSERT_OFF
	// a word in the input register always reaches the result register
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("input register word not carried to result register");

	// input side only stalls when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a held result");

	// an accepted word lands in the input register
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted word lost");
`endif

endmodule
